/* hdl/aoc_pkg.sv */
// ----------------------------------------------------------------------------
// aoc_pkg
// shared widths, register indexes, reset values and pixel type of the
// alpha over compositor
// ----------------------------------------------------------------------------
package aoc_pkg;

  localparam int CoordBits   = 12;
  localparam int SizeBits    = CoordBits + 1;
  localparam int ChanBits    = 3;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = SizeBits;
  localparam int PipeStages  = 8;

  localparam logic [CfgIdxBits-1:0] RegForeChannels = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegBackChannels = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegForeWidth    = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegBackHeight   = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegOffsetX      = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegOffsetY      = 3'd5;

  localparam logic [ChanBits-1:0] ChanGray      = 3'd1;
  localparam logic [ChanBits-1:0] ChanGrayAlpha = 3'd2;
  localparam logic [ChanBits-1:0] ChanRgb       = 3'd3;
  localparam logic [ChanBits-1:0] ChanRgba      = 3'd4;

  localparam logic [ChanBits-1:0]  ResetChannels  = ChanRgba;
  localparam logic [SizeBits-1:0]  ResetForeWidth = SizeBits'(640);
  localparam logic [SizeBits-1:0]  ResetBackHeight = SizeBits'(480);
  localparam logic [CoordBits-1:0] ResetOffset    = '0;

  localparam logic [7:0] Full = 8'hFF;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

endpackage

/* hdl/aoc_ifs.sv */
// ----------------------------------------------------------------------------
// aoc interfaces
// valid/ready channels for pixel input, pixel output and register writes
// ----------------------------------------------------------------------------
interface aoc_pix_in_if;
  logic                          valid;
  logic                          ready;
  logic [7:0]                    fore_b0;
  logic [7:0]                    fore_b1;
  logic [7:0]                    fore_b2;
  logic [7:0]                    fore_b3;
  logic [7:0]                    back_b0;
  logic [7:0]                    back_b1;
  logic [7:0]                    back_b2;
  logic [7:0]                    back_b3;
  logic [aoc_pkg::CoordBits-1:0] pos_x;
  logic [aoc_pkg::CoordBits-1:0] pos_y;

  modport source (
    output valid, fore_b0, fore_b1, fore_b2, fore_b3,
    output back_b0, back_b1, back_b2, back_b3, pos_x, pos_y,
    input  ready
  );
  modport sink (
    input  valid, fore_b0, fore_b1, fore_b2, fore_b3,
    input  back_b0, back_b1, back_b2, back_b3, pos_x, pos_y,
    output ready
  );
endinterface

interface aoc_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

interface aoc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [aoc_pkg::CfgIdxBits-1:0]  index;
  logic [aoc_pkg::CfgDataBits-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/alpha_over_compositor_core.sv */
// ----------------------------------------------------------------------------
// alpha_over_compositor_core
// expands foreground and background pixels to rgba and composites the
// foreground over the background inside the offset window
// ----------------------------------------------------------------------------
//  port    dir  beat contents
//  cfg_i   in   register index, write data
//  pix_i   in   fore_b0..3, back_b0..3, pos_x, pos_y
//  pix_o   out  red, green, blue, alpha
//
//  one pixel per cycle while pix_o is not stalled
//  stages: products, /255 reciprocal, /255 correction, sums, then a
//  two bits per stage divider ending in the output register
//  reset loads register defaults and empties the pipeline
//  a full stage holds while the next one cannot move; empty stages keep filling
//  config writes are always accepted
// ----------------------------------------------------------------------------
module alpha_over_compositor_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  aoc_cfg_if.sink       cfg_i,
  aoc_pix_in_if.sink    pix_i,
  aoc_pix_out_if.source pix_o
);

  typedef struct packed {
    logic                 in_win;
    aoc_pkg::rgba_t       fg;
    logic [2:0][15:0]     fprod;
    logic [2:0][7:0]      bcol;
    logic [15:0]          t;
  } s1_t;

  typedef struct packed {
    logic                 in_win;
    aoc_pkg::rgba_t       fg;
    logic [2:0][15:0]     fprod;
    logic [15:0]          t;
    logic [7:0]           tq0;
    logic [2:0][23:0]     gp;
  } s2_t;

  typedef struct packed {
    logic                 in_win;
    aoc_pkg::rgba_t       fg;
    logic [2:0][15:0]     fprod;
    logic [7:0]           ao;
    logic [2:0][23:0]     gp;
    logic [2:0][15:0]     gq0;
  } s3_t;

  typedef struct packed {
    logic                 in_win;
    aoc_pkg::rgba_t       fg;
    logic [7:0]           ao;
    logic [2:0][16:0]     num;
  } s4_t;

  typedef struct packed {
    logic                 in_win;
    aoc_pkg::rgba_t       fg;
    logic [7:0]           ao;
    logic [2:0]           sat;
    logic [2:0][16:0]     rem;
    logic [2:0][7:0]      quo;
  } div_t;

  function automatic aoc_pkg::rgba_t expand_px(input logic [aoc_pkg::ChanBits-1:0] ch,
                                               input logic [7:0] b0, input logic [7:0] b1,
                                               input logic [7:0] b2, input logic [7:0] b3);
    aoc_pkg::rgba_t px;
    case (ch)
      aoc_pkg::ChanGray:      px = {b0, b0, b0, aoc_pkg::Full};
      aoc_pkg::ChanGrayAlpha: px = {b0, b0, b0, b1};
      aoc_pkg::ChanRgb:       px = {b0, b1, b2, aoc_pkg::Full};
      default:                px = {b0, b1, b2, b3};
    endcase
    return px;
  endfunction

  // one restoring step: {quotient bit, new remainder}
  function automatic logic [17:0] div_step(input logic [16:0] rem, input logic [7:0] ao,
                                           input logic [2:0] sh);
    logic [16:0] trial;
    trial = 17'(ao) << sh;
    if (rem >= trial) begin
      return {1'b1, rem - trial};
    end
    return {1'b0, rem};
  endfunction

  // configuration registers
  logic [aoc_pkg::ChanBits-1:0]  fore_ch_q, fore_ch_d;
  logic [aoc_pkg::ChanBits-1:0]  back_ch_q, back_ch_d;
  logic [aoc_pkg::SizeBits-1:0]  fore_w_q, fore_w_d;
  logic [aoc_pkg::SizeBits-1:0]  back_h_q, back_h_d;
  logic [aoc_pkg::CoordBits-1:0] off_x_q, off_x_d;
  logic [aoc_pkg::CoordBits-1:0] off_y_q, off_y_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    fore_ch_d = fore_ch_q;
    back_ch_d = back_ch_q;
    fore_w_d  = fore_w_q;
    back_h_d  = back_h_q;
    off_x_d   = off_x_q;
    off_y_d   = off_y_q;
    if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        aoc_pkg::RegForeChannels: fore_ch_d = cfg_i.data[aoc_pkg::ChanBits-1:0];
        aoc_pkg::RegBackChannels: back_ch_d = cfg_i.data[aoc_pkg::ChanBits-1:0];
        aoc_pkg::RegForeWidth:    fore_w_d  = cfg_i.data[aoc_pkg::SizeBits-1:0];
        aoc_pkg::RegBackHeight:   back_h_d  = cfg_i.data[aoc_pkg::SizeBits-1:0];
        aoc_pkg::RegOffsetX:      off_x_d   = cfg_i.data[aoc_pkg::CoordBits-1:0];
        aoc_pkg::RegOffsetY:      off_y_d   = cfg_i.data[aoc_pkg::CoordBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fore_ch_q <= aoc_pkg::ResetChannels;
      back_ch_q <= aoc_pkg::ResetChannels;
      fore_w_q  <= aoc_pkg::ResetForeWidth;
      back_h_q  <= aoc_pkg::ResetBackHeight;
      off_x_q   <= aoc_pkg::ResetOffset;
      off_y_q   <= aoc_pkg::ResetOffset;
    end else begin
      fore_ch_q <= fore_ch_d;
      back_ch_q <= back_ch_d;
      fore_w_q  <= fore_w_d;
      back_h_q  <= back_h_d;
      off_x_q   <= off_x_d;
      off_y_q   <= off_y_d;
    end
  end

  // stage valids and per-stage enables
  logic [aoc_pkg::PipeStages-1:0] v_q, v_d, en;

  always_comb begin
    en[aoc_pkg::PipeStages-1] = !v_q[aoc_pkg::PipeStages-1] || pix_o.ready;
    for (int k = aoc_pkg::PipeStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d[0] = pix_i.valid;
    for (int k = 1; k < aoc_pkg::PipeStages; k++) begin
      v_d[k] = v_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < aoc_pkg::PipeStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  assign pix_i.ready = en[0];

  // stage 1: expand, window test, first products
  s1_t s1_q, s1_d;
  aoc_pkg::rgba_t fg, bg;
  logic signed [aoc_pkg::SizeBits+1:0] xlim;
  logic [aoc_pkg::SizeBits:0] ylim;

  always_comb begin
    fg = expand_px(fore_ch_q, pix_i.fore_b0, pix_i.fore_b1, pix_i.fore_b2, pix_i.fore_b3);
    bg = expand_px(back_ch_q, pix_i.back_b0, pix_i.back_b1, pix_i.back_b2, pix_i.back_b3);
    xlim = $signed({2'b00, fore_w_q}) - $signed({3'b000, off_x_q});
    ylim = {1'b0, back_h_q} + {2'b00, off_y_q};
    s1_d.in_win = (pix_i.pos_x >= off_x_q) && ($signed({3'b000, pix_i.pos_x}) < xlim) &&
                  (pix_i.pos_y >= off_y_q) && ({2'b00, pix_i.pos_y} < ylim);
    s1_d.fg       = fg;
    s1_d.fprod[0] = 16'(fg.r) * 16'(fg.a);
    s1_d.fprod[1] = 16'(fg.g) * 16'(fg.a);
    s1_d.fprod[2] = 16'(fg.b) * 16'(fg.a);
    s1_d.bcol[0]  = bg.r;
    s1_d.bcol[1]  = bg.g;
    s1_d.bcol[2]  = bg.b;
    s1_d.t        = 16'(bg.a) * 16'(aoc_pkg::Full - fg.a);
  end

  // stage 2: reciprocal estimate of t/255, background products
  s2_t s2_q, s2_d;
  logic [23:0] tsum;

  always_comb begin
    tsum        = {8'b0, s1_q.t} + {s1_q.t, 8'b0};
    s2_d.in_win = s1_q.in_win;
    s2_d.fg     = s1_q.fg;
    s2_d.fprod  = s1_q.fprod;
    s2_d.t      = s1_q.t;
    s2_d.tq0    = tsum[23:16];
    for (int c = 0; c < 3; c++) begin
      s2_d.gp[c] = 24'(s1_q.bcol[c]) * 24'(s1_q.t);
    end
  end

  // stage 3: output alpha, reciprocal estimate of background terms
  s3_t s3_q, s3_d;
  logic [15:0] tr;
  logic [2:0][31:0] gsum;

  always_comb begin
    tr          = s2_q.t - ({s2_q.tq0, 8'b0} - {8'b0, s2_q.tq0});
    s3_d.in_win = s2_q.in_win;
    s3_d.fg     = s2_q.fg;
    s3_d.fprod  = s2_q.fprod;
    s3_d.gp     = s2_q.gp;
    s3_d.ao     = s2_q.fg.a + ((tr >= 16'(aoc_pkg::Full)) ? s2_q.tq0 + 8'd1 : s2_q.tq0);
    for (int c = 0; c < 3; c++) begin
      gsum[c]     = {8'b0, s2_q.gp[c]} + {s2_q.gp[c], 8'b0};
      s3_d.gq0[c] = gsum[c][31:16];
    end
  end

  // stage 4: correct background terms, color numerators
  s4_t s4_q, s4_d;
  logic [2:0][23:0] gr;
  logic [2:0][15:0] gq;

  always_comb begin
    s4_d.in_win = s3_q.in_win;
    s4_d.fg     = s3_q.fg;
    s4_d.ao     = s3_q.ao;
    for (int c = 0; c < 3; c++) begin
      gr[c] = s3_q.gp[c] - ({s3_q.gq0[c], 8'b0} - {8'b0, s3_q.gq0[c]});
      gq[c] = (gr[c] >= 24'(aoc_pkg::Full)) ? s3_q.gq0[c] + 16'd1 : s3_q.gq0[c];
      s4_d.num[c] = 17'(s3_q.fprod[c]) + 17'(gq[c]);
    end
  end

  // divider stages, two quotient bits each
  div_t d0_q, d0_d, d1_q, d1_d, d2_q, d2_d;
  logic [2:0][17:0] st0a, st0b, st1a, st1b, st2a, st2b;

  always_comb begin
    d0_d.in_win = s4_q.in_win;
    d0_d.fg     = s4_q.fg;
    d0_d.ao     = s4_q.ao;
    for (int c = 0; c < 3; c++) begin
      d0_d.sat[c] = s4_q.num[c] >= {1'b0, s4_q.ao, 8'b0};
      st0a[c]     = div_step(s4_q.num[c], s4_q.ao, 3'd7);
      st0b[c]     = div_step(st0a[c][16:0], s4_q.ao, 3'd6);
      d0_d.rem[c] = st0b[c][16:0];
      d0_d.quo[c] = {st0a[c][17], st0b[c][17], 6'b0};
    end
  end

  always_comb begin
    d1_d = d0_q;
    for (int c = 0; c < 3; c++) begin
      st1a[c]        = div_step(d0_q.rem[c], d0_q.ao, 3'd5);
      st1b[c]        = div_step(st1a[c][16:0], d0_q.ao, 3'd4);
      d1_d.rem[c]    = st1b[c][16:0];
      d1_d.quo[c][5] = st1a[c][17];
      d1_d.quo[c][4] = st1b[c][17];
    end
  end

  always_comb begin
    d2_d = d1_q;
    for (int c = 0; c < 3; c++) begin
      st2a[c]        = div_step(d1_q.rem[c], d1_q.ao, 3'd3);
      st2b[c]        = div_step(st2a[c][16:0], d1_q.ao, 3'd2);
      d2_d.rem[c]    = st2b[c][16:0];
      d2_d.quo[c][3] = st2a[c][17];
      d2_d.quo[c][2] = st2b[c][17];
    end
  end

  // output stage: last two bits, zero alpha, saturation, pass-through
  aoc_pkg::rgba_t out_q, out_d;
  logic [2:0][17:0] st3a, st3b;
  logic [2:0][7:0] quo_f, col;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      st3a[c]  = div_step(d2_q.rem[c], d2_q.ao, 3'd1);
      st3b[c]  = div_step(st3a[c][16:0], d2_q.ao, 3'd0);
      quo_f[c] = {d2_q.quo[c][7:2], st3a[c][17], st3b[c][17]};
      if (d2_q.ao == 8'd0) begin
        col[c] = 8'd0;
      end else if (d2_q.sat[c]) begin
        col[c] = aoc_pkg::Full;
      end else begin
        col[c] = quo_f[c];
      end
    end
    if (d2_q.in_win) begin
      out_d = {col[0], col[1], col[2], d2_q.ao};
    end else begin
      out_d = d2_q.fg;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_q <= s1_d;
    end
    if (en[1]) begin
      s2_q <= s2_d;
    end
    if (en[2]) begin
      s3_q <= s3_d;
    end
    if (en[3]) begin
      s4_q <= s4_d;
    end
    if (en[4]) begin
      d0_q <= d0_d;
    end
    if (en[5]) begin
      d1_q <= d1_d;
    end
    if (en[6]) begin
      d2_q <= d2_d;
    end
    if (en[7]) begin
      out_q <= out_d;
    end
  end

  assign pix_o.valid = v_q[aoc_pkg::PipeStages-1];
  assign pix_o.red   = out_q.r;
  assign pix_o.green = out_q.g;
  assign pix_o.blue  = out_q.b;
  assign pix_o.alpha = out_q.a;

  // empty output register means the whole pipe can move
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_o.valid |-> pix_i.ready)
    else $error("input stalled with empty output stage");

  a_accept_fills_stage1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.valid && pix_i.ready |=> v_q[0])
    else $error("accepted beat not in first stage");

  a_alpha_not_below_fg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[2] |-> s3_q.ao >= s3_q.fg.a)
    else $error("output alpha below foreground alpha");

  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[5] && !d1_q.sat[0] |-> d1_q.rem[0] < (17'(d1_q.ao) << 4))
    else $error("divider remainder out of range");

endmodule
